// ===== rtl/mme_pkg.sv =====
// Package for the matrix multiply engine: sizes, field widths, codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package mme_pkg;

  localparam int MAX_DIM  = 8;
  localparam int IDX_W    = 3;
  localparam int SIZE_W   = 4;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int MODE_W   = 2;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 36;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_B_COLS     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;
    logic              first;
    logic              last;
    logic              zero;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              load_out;
    logic [IDX_W-1:0]  res_row;
    logic [IDX_W-1:0]  res_col;
    logic              res_last;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_ready;
    logic out_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    elem_addr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/mme_in_if.sv =====
// Input channel of the matrix multiply engine: valid/ready plus one load or compute item.
// Depends on mme_pkg.
interface mme_in_if;
  logic                                valid;
  logic                                ready;
  logic [mme_pkg::MODE_W-1:0]          mode;
  logic [mme_pkg::IDX_W-1:0]           row_index;
  logic [mme_pkg::IDX_W-1:0]           col_index;
  logic signed [mme_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, mode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

// ===== rtl/mme_out_if.sv =====
// Output channel of the matrix multiply engine: valid/ready plus one result element.
// Depends on mme_pkg.
interface mme_out_if;
  logic                                valid;
  logic                                ready;
  logic [mme_pkg::IDX_W-1:0]           out_row;
  logic [mme_pkg::IDX_W-1:0]           out_col;
  logic signed [mme_pkg::PROD_W-1:0]   product_value;
  logic                                saturated;
  logic                                last_result;

  modport source (output valid, out_row, out_col, product_value, saturated, last_result,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_value, saturated, last_result,
                  output ready);
endinterface

// ===== rtl/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/mme_datapath.sv =====
// Datapath: A and B element stores, multiply and accumulate pipeline,
// saturation and the output register. Depends on mme_pkg, mme_ram, mme_out_if.
module mme_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mme_pkg::dp_cmd_t                  cmd,
  input  logic signed [mme_pkg::ELEM_W-1:0] wr_data,
  output mme_pkg::dp_status_t               status,
  mme_out_if.source                         out_ch
);
  import mme_pkg::*;

  logic [ELEM_W-1:0]        rd_a;
  logic [ELEM_W-1:0]        rd_b;
  logic                     v1, first1, last1, zero1;
  logic                     v2, first2, last2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_ready;
  logic                     out_valid;
  logic                     sat;
  logic signed [PROD_W-1:0] sat_value;
  logic [ACC_W-PROD_W:0]    upper;

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.we_a),
    .waddr (cmd.wr_addr),
    .wdata (wr_data),
    .re    (cmd.issue),
    .raddr (cmd.rd_addr_a),
    .rdata (rd_a)
  );

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.we_b),
    .waddr (cmd.wr_addr),
    .wdata (wr_data),
    .re    (cmd.issue),
    .raddr (cmd.rd_addr_b),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      acc_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.load_out) begin
        acc_ready <= 1'b0;
      end else if (v2 && last2) begin
        acc_ready <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first1 <= cmd.first;
    last1  <= cmd.last;
    zero1  <= cmd.zero;
    first2 <= first1;
    last2  <= last1;
    if (v1) begin
      if (zero1) begin
        prod2 <= '0;
      end else begin
        prod2 <= $signed(rd_a) * $signed(rd_b);
      end
    end
    if (v2) begin
      acc <= (first2 ? '0 : acc) + ACC_W'(prod2);
    end
  end

  // The sum fits in 32 bits when all bits from bit 31 upward agree.
  always_comb begin
    upper     = acc[ACC_W-1:PROD_W-1];
    sat       = !((&upper) || (~|upper));
    sat_value = acc[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.out_row       <= cmd.res_row;
      out_ch.out_col       <= cmd.res_col;
      out_ch.product_value <= sat ? sat_value : acc[PROD_W-1:0];
      out_ch.saturated     <= sat;
      out_ch.last_result   <= cmd.res_last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign status.acc_ready = acc_ready;
  assign status.out_free  = !out_valid || out_ch.ready;
endmodule

// ===== rtl/mme_ctrl.sv =====
// Controller: size registers, input handshake and the row/column/inner-index
// sequencer that drives the datapath. Depends on mme_pkg and mme_in_if.
module mme_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mme_pkg::SIZE_W-1:0]           cfg_data,
  mme_in_if.sink                               in_ch,
  input  mme_pkg::dp_status_t                  status,
  output mme_pkg::dp_cmd_t                     cmd
);
  import mme_pkg::*;

  ctrl_state_t       state, state_next;
  logic [SIZE_W-1:0] a_rows, inner_size, b_cols;
  logic [SIZE_W-1:0] nr, nk, nc;
  logic [IDX_W-1:0]  i, i_next, j, j_next, k, k_next;
  logic              last_k, last_i, last_j;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    eff_size = (r > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= SIZE_W'(MAX_DIM);
      inner_size <= SIZE_W'(MAX_DIM);
      b_cols     <= SIZE_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A_ROWS:     a_rows     <= cfg_data;
        CFG_INNER_SIZE: inner_size <= cfg_data;
        CFG_B_COLS:     b_cols     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr = eff_size(a_rows);
  assign nk = eff_size(inner_size);
  assign nc = eff_size(b_cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
    end
  end

  assign last_k = ({1'b0, k} == nk - SIZE_W'(1));
  assign last_i = ({1'b0, i} == nr - SIZE_W'(1));
  assign last_j = ({1'b0, j} == nc - SIZE_W'(1));

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    cmd         = '0;
    cmd.wr_addr = elem_addr(in_ch.row_index, in_ch.col_index);
    cmd.rd_addr_a = elem_addr(i, k);
    cmd.rd_addr_b = elem_addr(k, j);
    cmd.res_row = i;
    cmd.res_col = j;
    cmd.res_last = last_i && last_j;
    in_ch.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (mode_t'(in_ch.mode))
            MODE_LOAD_A: begin
              cmd.we_a = ({1'b0, in_ch.row_index} < nr) && ({1'b0, in_ch.col_index} < nk);
            end
            MODE_LOAD_B: begin
              cmd.we_b = ({1'b0, in_ch.row_index} < nk) && ({1'b0, in_ch.col_index} < nc);
            end
            MODE_COMPUTE: begin
              // An empty result matrix produces no items at all.
              if (nr != '0 && nc != '0) begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                state_next = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        // With no inner dimension a single forced-zero product clears the sum.
        cmd.issue = 1'b1;
        cmd.first = (k == '0);
        cmd.zero  = (nk == '0);
        cmd.last  = (nk == '0) || last_k;
        if (cmd.last) begin
          k_next = '0;
          state_next = ST_WAIT;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (status.acc_ready && status.out_free) begin
          cmd.load_out = 1'b1;
          if (last_i && last_j) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            if (last_j) begin
              j_next = '0;
              i_next = i + IDX_W'(1);
            end else begin
              j_next = j + IDX_W'(1);
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/matrix_multiply_engine_unit.sv =====
// Top level of the matrix multiply engine: controller plus datapath.
// Depends on mme_pkg, mme_in_if, mme_out_if, mme_ctrl, mme_datapath.
//
//   channel  direction  payload
//   in_ch    in         mode, row_index, col_index, element_value
//   out_ch   out        out_row, out_col, product_value, saturated, last_result
//   cfg      in         cfg_we, cfg_index, cfg_data (a_rows, inner_size, b_cols)
//
// A load item is accepted in ST_IDLE. A compute item is accepted in ST_IDLE and then, for
// each result element, issues one store read per inner step (at least one), passes through the
// read, multiply and accumulate stages and hands the sum to the output register.
// Input ready is low for the whole compute item; a stalled output holds the sequencer.
// Reset sets all sizes to 8; the element stores are not cleared.
module matrix_multiply_engine_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mme_pkg::SIZE_W-1:0]     cfg_data,
  mme_in_if.sink                         in_ch,
  mme_out_if.source                      out_ch
);
  import mme_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .status    (status),
    .cmd       (cmd)
  );

  mme_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_data (in_ch.element_value),
    .status  (status),
    .out_ch  (out_ch)
  );
endmodule

// ===== tb/matrix_multiply_engine_unit_tb.sv =====
// Self-checking testbench for matrix_multiply_engine_unit: loads A and B, runs compute items
// and compares every result element against a fixed-point predictor held in a scoreboard.
// Depends on mme_pkg, mme_in_if, mme_out_if and the engine RTL.
module matrix_multiply_engine_unit_tb;
  import mme_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] value;
    logic                     sat;
    logic                     last;
  } product_t;

  class matmul_checker;
    logic signed [ELEM_W-1:0] a_store[DEPTH];
    logic signed [ELEM_W-1:0] b_store[DEPTH];
    bit a_known[DEPTH];
    bit b_known[DEPTH];
    int unsigned nr = MAX_DIM;
    int unsigned nk = MAX_DIM;
    int unsigned nc = MAX_DIM;
    product_t pending_products[$];
    int unsigned checked;
    int unsigned clipped;
    int unsigned failures;

    function int unsigned clip_dim(logic [SIZE_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function void set_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] inner,
                            logic [SIZE_W-1:0] cols);
      nr = clip_dim(rows);
      nk = clip_dim(inner);
      nc = clip_dim(cols);
    endfunction

    // Appends every element of C for the current sizes, row-major.
    function void multiply_out();
      int unsigned i, j, k;
      longint acc;
      product_t p;
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = 0;
          for (k = 0; k < nk; k++)
            acc += longint'(a_store[i * MAX_DIM + k]) * longint'(b_store[k * MAX_DIM + j]);
          p.row = IDX_W'(i);
          p.col = IDX_W'(j);
          p.sat = 1'b0;
          if (acc > 64'sd2147483647) begin
            p.value = 32'sh7FFFFFFF;
            p.sat = 1'b1;
          end else if (acc < -64'sd2147483648) begin
            p.value = 32'sh80000000;
            p.sat = 1'b1;
          end else begin
            p.value = PROD_W'(acc);
          end
          p.last = (i == nr - 1) && (j == nc - 1);
          pending_products.push_back(p);
        end
      end
    endfunction

    // Returns 1 for a load inside the current sizes and for every compute item.
    function bit take_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic signed [ELEM_W-1:0] v);
      int unsigned ix;
      ix = r * MAX_DIM + c;
      case (m)
        MODE_LOAD_A: begin
          if (r < nr && c < nk) begin
            a_store[ix] = v;
            a_known[ix] = 1'b1;
            return 1'b1;
          end
        end
        MODE_LOAD_B: begin
          if (r < nk && c < nc) begin
            b_store[ix] = v;
            b_known[ix] = 1'b1;
            return 1'b1;
          end
        end
        MODE_COMPUTE: begin
          multiply_out();
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void report(string field, logic signed [PROD_W-1:0] want_v,
                         logic signed [PROD_W-1:0] got_v);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
      failures++;
    endfunction

    function void check_product(product_t got);
      product_t want;
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result: expected none, got row %0d col %0d value %0d",
                 $time, got.row, got.col, got.value);
        failures++;
        return;
      end
      want = pending_products.pop_front();
      checked++;
      if (want.sat) clipped++;
      if (got.row !== want.row) report("out_row", PROD_W'(want.row), PROD_W'(got.row));
      if (got.col !== want.col) report("out_col", PROD_W'(want.col), PROD_W'(got.col));
      if (got.value !== want.value) report("product_value", want.value, got.value);
      if (got.sat !== want.sat) report("saturated", PROD_W'(want.sat), PROD_W'(got.sat));
      if (got.last !== want.last)
        report("last_result", PROD_W'(want.last), PROD_W'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  mme_in_if in_ch ();
  mme_out_if out_ch ();

  matrix_multiply_engine_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  matmul_checker sb = new;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  int unsigned useful_items;
  int unsigned size_settings;
  int unsigned computes;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("matrix_multiply_engine_unit_tb: done, errors");
    $finish;
  end

  // Result side: check at each handshake, then pick the next ready level.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_product('{out_ch.out_row, out_ch.out_col, out_ch.product_value,
                           out_ch.saturated, out_ch.last_result});
      out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high across back-to-back items; it only drops for a gap or a pause.
  task automatic send_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [ELEM_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.row_index <= r;
    in_ch.col_index <= c;
    in_ch.element_value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (sb.take_item(m, r, c, v)) useful_items++;
    if (m == MODE_COMPUTE) computes++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] inner,
                             logic [SIZE_W-1:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= CFG_A_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_INNER_SIZE;
    cfg_data <= inner;
    @(posedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_sizes(rows, inner, cols);
    size_settings++;
  endtask

  function automatic logic [ELEM_W-1:0] elem_pick();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly sizes of one to four; sometimes zero, five to seven, the full size or a value past it.
  function automatic logic [SIZE_W-1:0] dim_pick();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return 4'd0;
    if (pick < 68) return SIZE_W'($urandom_range(4, 1));
    if (pick < 80) return SIZE_W'($urandom_range(7, 5));
    if (pick < 92) return 4'd8;
    return SIZE_W'($urandom_range(15, 9));
  endfunction

  task automatic random_load();
    int unsigned pick;
    int unsigned row_lim;
    int unsigned col_lim;
    logic [MODE_W-1:0] m;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    pick = $urandom_range(99);
    m = pick[0] ? MODE_LOAD_B : MODE_LOAD_A;
    row_lim = (m == MODE_LOAD_A) ? sb.nr : sb.nk;
    col_lim = (m == MODE_LOAD_A) ? sb.nk : sb.nc;
    r = IDX_W'($urandom_range(7));
    c = IDX_W'($urandom_range(7));
    if (pick < 6) begin
      m = MODE_UNUSED;
    end else if (pick < 85 && row_lim > 0 && col_lim > 0) begin
      r = IDX_W'($urandom_range(row_lim - 1));
      c = IDX_W'($urandom_range(col_lim - 1));
    end
    send_item(m, r, c, elem_pick());
  endtask

  // A compute item must never read an entry that was not loaded since reset.
  task automatic fill_missing();
    int unsigned i;
    int unsigned j;
    if (sb.nr == 0 || sb.nk == 0 || sb.nc == 0) return;
    for (i = 0; i < sb.nr; i++)
      for (j = 0; j < sb.nk; j++)
        if (!sb.a_known[i * MAX_DIM + j])
          send_item(MODE_LOAD_A, IDX_W'(i), IDX_W'(j), elem_pick());
    for (i = 0; i < sb.nk; i++)
      for (j = 0; j < sb.nc; j++)
        if (!sb.b_known[i * MAX_DIM + j])
          send_item(MODE_LOAD_B, IDX_W'(i), IDX_W'(j), elem_pick());
  endtask

  initial begin
    int unsigned k;
    int unsigned random_start;
    int unsigned done_part;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_A_ROWS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_LOAD_A;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.element_value <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Row 0 of A times column 0 of B clips high, times column 1 clips low.
    write_sizes(4'd2, 4'd3, 4'd2);
    for (k = 0; k < 3; k++) begin
      send_item(MODE_LOAD_A, 3'd0, IDX_W'(k), 16'h8000);
      send_item(MODE_LOAD_A, 3'd1, IDX_W'(k), (k == 0) ? 16'h0100 : 16'hFFFF);
      send_item(MODE_LOAD_B, IDX_W'(k), 3'd0, 16'h8000);
      send_item(MODE_LOAD_B, IDX_W'(k), 3'd1, 16'h7FFF);
    end
    send_item(MODE_LOAD_A, 3'd7, 3'd0, 16'h1234);
    send_item(MODE_LOAD_B, 3'd0, 3'd7, 16'h4321);
    send_item(MODE_LOAD_B, 3'd3, 3'd1, 16'h5555);
    send_item(MODE_UNUSED, 3'd7, 3'd7, 16'hFFFF);
    send_item(MODE_COMPUTE, 3'd7, 3'd7, 16'h0000);
    wait_drained();
    write_sizes(4'd0, 4'd3, 4'd2);
    send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'hFFFF);
    wait_drained();
    // Zero inner size: a full 8x8 of zeros, with both sizes past the maximum.
    write_sizes(4'd15, 4'd0, 4'd15);
    send_item(MODE_COMPUTE, 3'd5, 3'd2, 16'hA5A5);
    wait_drained();
    write_sizes(4'd1, 4'd1, 4'd1);
    send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      done_part = (items_sent - random_start) * 3 / RANDOM_ITEMS;
      case (done_part)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      write_sizes(dim_pick(), dim_pick(), dim_pick());
      repeat ($urandom_range(10)) random_load();
      fill_missing();
      send_item(MODE_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                elem_pick());
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(4)) random_load();
        fill_missing();
        send_item(MODE_COMPUTE, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                  elem_pick());
      end
    end
    wait_drained();

    $display("Sent %0d items (%0d compute, %0d that took effect) over %0d size settings.",
             items_sent, computes, useful_items, size_settings);
    $display("Checked %0d result elements, %0d of them clipped, %0d mismatches.",
             sb.checked, sb.clipped, sb.failures);
    if (sb.failures == 0) begin
      $display("matrix_multiply_engine_unit_tb: done, clean");
    end else begin
      $display("matrix_multiply_engine_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
